@@ hw/rtl/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN signal extract/insert package
// Shared types, constants and register indexes for the signal bit-field block.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned PayloadW     = 8 * PayloadBytes;
  localparam int unsigned ValueW       = 64;
  localparam int unsigned LenW         = 4;
  localparam int unsigned PosW         = 6;
  localparam int unsigned SizeW        = 7;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMsbPos    = 2'd0,
    CfgLsbPos    = 2'd1,
    CfgSigSize   = 2'd2,
    CfgLittleEnd = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpExtract = 1'b0,
    OpInsert  = 1'b1
  } op_e;

  typedef struct packed {
    logic [PosW-1:0]  msb_position;
    logic [PosW-1:0]  lsb_position;
    logic [SizeW-1:0] signal_size;
    logic             little_endian;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic [PayloadW-1:0] payload;
    logic [LenW-1:0]     payload_length;
    logic [ValueW-1:0]   raw_value;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0]   extracted_value;
    logic [PayloadW-1:0] updated_payload;
  } result_t;

endpackage

@@ hw/rtl/can_signal_extract_insert.sv @@
// ----------------------------------------------------------------------------
// CAN signal extract/insert
// Extracts a raw signal from, or inserts it into, one classic CAN payload.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge where start_i is high; busy_o
// stays low, so one frame can be issued in every cycle. Each transaction
// produces exactly one result, through the input register and then the
// result register, shown for one cycle with done_o high, in issue order.
// The receiver cannot stall the block and must take every result in its
// cycle. Both registers lie around the single pass of byte-walk logic.
// Configuration must be written through cfg_we_i only while no
// transaction is in flight; the block itself does not enforce this.
module can_signal_extract_insert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  cse_pkg::item_t                 item_i,
  output logic                           done_o,
  output cse_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [cse_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cse_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  cse_pkg::cfg_t    cfg_q;
  logic             valid_q;
  cse_pkg::item_t   item_q;
  logic             done_q;
  cse_pkg::result_t res_q;
  cse_pkg::result_t res_d;

  logic [cse_pkg::LenW-1:0]     len;
  logic [cse_pkg::ValueW-1:0]   ext_value;
  logic [cse_pkg::PayloadW-1:0] ins_payload;
  logic                         accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msb_position  <= 6'd7;
      cfg_q.lsb_position  <= 6'd0;
      cfg_q.signal_size   <= 7'd8;
      cfg_q.little_endian <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cse_pkg::CfgMsbPos:    cfg_q.msb_position  <= cfg_wdata_i[cse_pkg::PosW-1:0];
        cse_pkg::CfgLsbPos:    cfg_q.lsb_position  <= cfg_wdata_i[cse_pkg::PosW-1:0];
        cse_pkg::CfgSigSize:   cfg_q.signal_size   <= cfg_wdata_i[cse_pkg::SizeW-1:0];
        cse_pkg::CfgLittleEnd: cfg_q.little_endian <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  assign len = (item_q.payload_length > cse_pkg::LenW'(cse_pkg::PayloadBytes))
             ? cse_pkg::LenW'(cse_pkg::PayloadBytes) : item_q.payload_length;

  cse_extract u_extract (
    .cfg_i     (cfg_q),
    .payload_i (item_q.payload),
    .len_i     (len),
    .value_o   (ext_value)
  );

  cse_insert u_insert (
    .cfg_i     (cfg_q),
    .payload_i (item_q.payload),
    .len_i     (len),
    .value_i   (item_q.raw_value),
    .payload_o (ins_payload)
  );

  always_comb begin
    if (item_q.op == cse_pkg::OpInsert) begin
      res_d.extracted_value = '0;
      res_d.updated_payload = ins_payload;
    end else begin
      res_d.extracted_value = ext_value;
      res_d.updated_payload = item_q.payload;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q))
    else $error("result without a transaction in flight");

  a_extract_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> (res_q.extracted_value == '0)
                || (res_q.updated_payload == $past(item_q.payload)))
    else $error("extract result altered the payload");

  a_empty_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && item_q.op == cse_pkg::OpInsert && item_q.payload_length == '0
      |=> res_q.updated_payload == $past(item_q.payload))
    else $error("insert into an empty payload changed it");

endmodule

@@ hw/rtl/cse_extract.sv @@
// ----------------------------------------------------------------------------
// Signal extract
// Walks the payload bytes from the msb byte and assembles the raw value.
// ----------------------------------------------------------------------------
module cse_extract (
  input  cse_pkg::cfg_t                   cfg_i,
  input  logic [cse_pkg::PayloadW-1:0]    payload_i,
  input  logic [cse_pkg::LenW-1:0]        len_i,
  output logic [cse_pkg::ValueW-1:0]      value_o
);

  logic [2:0] msb_byte;
  logic [2:0] lsb_byte;

  assign msb_byte = cfg_i.msb_position[5:3];
  assign lsb_byte = cfg_i.lsb_position[5:3];

  always_comb begin
    logic signed [8:0]         bits;
    logic                      active;
    logic signed [4:0]         idx;
    logic [2:0]                lo_b;
    logic [2:0]                hi_b;
    logic signed [4:0]         w;
    logic signed [8:0]         sh;
    logic signed [8:0]         nsh;
    logic [7:0]                byte_v;
    logic [7:0]                d;
    logic [cse_pkg::ValueW-1:0] d_ext;
    logic [cse_pkg::ValueW-1:0] acc;

    bits   = $signed({2'b00, cfg_i.signal_size});
    active = 1'b1;
    acc    = '0;
    for (int k = 0; k < cse_pkg::PayloadBytes; k++) begin
      if (cfg_i.little_endian) begin
        idx = $signed({2'b00, msb_byte}) - $signed(5'(k));
      end else begin
        idx = $signed({2'b00, msb_byte}) + $signed(5'(k));
      end
      if (idx < 5'sd0 || idx >= $signed({1'b0, len_i}) || bits <= 9'sd0) begin
        active = 1'b0;
      end
      lo_b   = (idx == $signed({2'b00, lsb_byte})) ? cfg_i.lsb_position[2:0] : 3'd0;
      hi_b   = (idx == $signed({2'b00, msb_byte})) ? cfg_i.msb_position[2:0] : 3'd7;
      w      = $signed({2'b00, hi_b}) - $signed({2'b00, lo_b}) + 5'sd1;
      byte_v = payload_i[{idx[2:0], 3'b000} +: 8];
      d      = (byte_v >> lo_b) & (8'hFF >> (4'd8 - w[3:0]));
      d_ext  = {{(cse_pkg::ValueW-8){1'b0}}, d};
      sh     = bits - {{4{w[4]}}, w};
      nsh    = -sh;
      if (active && w > 5'sd0) begin
        if (!sh[8] && sh[7:6] == 2'b00) begin
          acc = acc | (d_ext << sh[5:0]);
        end else if (sh[8]) begin
          acc = acc | (d_ext >> nsh[2:0]);
        end
        bits = sh;
      end
    end
    value_o = acc;
  end

endmodule

@@ hw/rtl/cse_insert.sv @@
// ----------------------------------------------------------------------------
// Signal insert
// Writes the size-masked value into the payload bytes from the lsb byte on.
// ----------------------------------------------------------------------------
module cse_insert (
  input  cse_pkg::cfg_t                   cfg_i,
  input  logic [cse_pkg::PayloadW-1:0]    payload_i,
  input  logic [cse_pkg::LenW-1:0]        len_i,
  input  logic [cse_pkg::ValueW-1:0]      value_i,
  output logic [cse_pkg::PayloadW-1:0]    payload_o
);

  logic [2:0]                  bit_ofs;
  logic [2:0]                  lsb_byte;
  logic [7:0]                  lim;
  logic [cse_pkg::PayloadW-1:0] stream;
  logic [cse_pkg::PayloadW-1:0] hi_mask;
  logic [cse_pkg::PayloadW-1:0] lo_mask;
  logic [cse_pkg::PayloadW-1:0] smask;
  logic                        start_ok;

  assign bit_ofs  = cfg_i.lsb_position[2:0];
  assign lsb_byte = cfg_i.lsb_position[5:3];
  assign lim      = {5'b00000, bit_ofs} + {1'b0, cfg_i.signal_size};
  assign stream   = value_i << bit_ofs;
  assign hi_mask  = (lim >= 8'd64) ? '1 : ((64'd1 << lim[5:0]) - 64'd1);
  assign lo_mask  = ~((64'd1 << bit_ofs) - 64'd1);
  assign smask    = hi_mask & lo_mask;
  assign start_ok = {1'b0, lsb_byte} < len_i;

  always_comb begin
    logic signed [3:0] k;
    logic [7:0]        sb;
    logic [7:0]        mb;
    logic [7:0]        pb;

    payload_o = payload_i;
    for (int i = 0; i < cse_pkg::PayloadBytes; i++) begin
      if (cfg_i.little_endian) begin
        k = $signed(4'(i)) - $signed({1'b0, lsb_byte});
      end else begin
        k = $signed({1'b0, lsb_byte}) - $signed(4'(i));
      end
      sb = stream[{k[2:0], 3'b000} +: 8];
      mb = smask[{k[2:0], 3'b000} +: 8];
      pb = payload_i[i*8 +: 8];
      if (!k[3] && start_ok && 4'(i) < len_i) begin
        payload_o[i*8 +: 8] = (pb & ~mb) | (sb & mb);
      end
    end
  end

endmodule
